// File: rtl/core/oss_pkg.sv
`timescale 1ns / 1ps
package oss_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	typedef enum logic [3:0] {
		OP_PUSH    = 4'd0,
		OP_POP     = 4'd1,
		OP_POP2    = 4'd2,
		OP_DUP     = 4'd3,
		OP_DUP_X1  = 4'd4,
		OP_DUP_X2  = 4'd5,
		OP_DUP2    = 4'd6,
		OP_DUP2_X1 = 4'd7,
		OP_DUP2_X2 = 4'd8,
		OP_SWAP    = 4'd9
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_UNDER   = 2'd2,
		ST_OVER    = 2'd3
	} status_t;

	// source of one entry placed back on the stack
	typedef enum logic [2:0] {
		SEL_V1   = 3'd0,
		SEL_V2   = 3'd1,
		SEL_V3   = 3'd2,
		SEL_V4   = 3'd3,
		SEL_PUSH = 3'd4
	} sel_t;

	typedef struct packed {
		logic       cap_in;
		logic       rd;
		logic       cap_v;
		logic [1:0] idx;
		logic       dec;
		logic       wr;
		logic [2:0] widx;
		logic       top_cap;
		logic       load_out;
	} oss_cmd_t;

	typedef struct packed {
		logic [2:0] cnt;
	} oss_stat_t;

endpackage

// File: rtl/core/oss_ctrl.sv
`timescale 1ns / 1ps
module oss_ctrl
	import oss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  oss_stat_t stat,
	output oss_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_RW   = 8'b0000_0100,
		S_DEC  = 8'b0000_1000,
		S_WR   = 8'b0001_0000,
		S_TRD  = 8'b0010_0000,
		S_TWT  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] ridx_q;
	logic [2:0] widx_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.idx = ridx_q;
		cmd.widx = widx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_RW;
			end
			S_RW: begin
				cmd.cap_v = 1'b1;
				state_d = (ridx_q == 2'd3) ? S_DEC : S_RD;
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				if (stat.cnt == 3'd0) begin
					state_d = S_TRD;
				end else begin
					cmd.wr = 1'b1;
					if (widx_q == stat.cnt - 3'd1)
						state_d = S_TRD;
				end
			end
			S_TRD: begin
				cmd.rd = 1'b1;
				cmd.idx = 2'd0;
				state_d = S_TWT;
			end
			S_TWT: begin
				cmd.top_cap = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ridx_q <= '0;
			widx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE)
				ridx_q <= '0;
			else if (cmd.cap_v)
				ridx_q <= ridx_q + 2'd1;
			if (state_q == S_DEC)
				widx_q <= '0;
			else if (cmd.wr)
				widx_q <= widx_q + 3'd1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/oss_dp.sv
`timescale 1ns / 1ps
module oss_dp
	import oss_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  oss_cmd_t               cmd,
	output oss_stat_t              stat,
	input  logic [3:0]             opcode,
	input  logic [VALUE_WIDTH-1:0] push_value,
	input  logic                   push_wide,
	output logic [1:0]             status,
	output logic [6:0]             stack_depth,
	output logic [VALUE_WIDTH-1:0] top_value,
	output logic                   top_wide
);

	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int EW    = VALUE_WIDTH + 1;

	logic [EW-1:0]          mem [STACK_DEPTH];
	logic [EW-1:0]          rdata_q;
	logic                   rd_ok_q;
	logic [CNT_W-1:0]       count_q;
	logic [3:0]             op_q;
	logic [VALUE_WIDTH-1:0] push_val_q;
	logic                   push_w_q;
	logic [VALUE_WIDTH-1:0] v_val_q [4];
	logic                   v_w_q [4];
	sel_t                   sel_q [6];
	status_t                stat_q;
	logic [CNT_W-1:0]       base_q;
	logic [2:0]             cnt_q;
	logic [EW-1:0]          top_q;

	logic [PTR_W-1:0] raddr, waddr;
	logic [EW-1:0]    wdata;
	logic [2:0]       need, consume, cnt;
	sel_t             sel [6];
	logic             inval;
	logic [CNT_W:0]   nx, after;
	status_t          st;

	assign stat.cnt = cnt_q;

	assign raddr = PTR_W'(count_q - CNT_W'(cmd.idx) - CNT_W'(1));
	assign waddr = PTR_W'(base_q + CNT_W'(cmd.widx));

	always_comb begin
		unique case (sel_q[cmd.widx])
			SEL_V1:   wdata = {v_w_q[0], v_val_q[0]};
			SEL_V2:   wdata = {v_w_q[1], v_val_q[1]};
			SEL_V3:   wdata = {v_w_q[2], v_val_q[2]};
			SEL_V4:   wdata = {v_w_q[3], v_val_q[3]};
			SEL_PUSH: wdata = {push_w_q, push_val_q};
			default:  wdata = {push_w_q, push_val_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[waddr] <= wdata;
		if (cmd.rd)
			rdata_q <= mem[raddr];
	end

	// form selection from the flags of the top entries
	always_comb begin
		need = 3'd0;
		consume = 3'd0;
		cnt = 3'd0;
		inval = 1'b0;
		for (int i = 0; i < 6; i++)
			sel[i] = SEL_V1;
		unique case (op_q)
			OP_PUSH: begin
				cnt = 3'd1; sel[0] = SEL_PUSH;
			end
			OP_POP: consume = 3'd1;
			OP_POP2: begin
				need = 3'd1;
				consume = v_w_q[0] ? 3'd1 : 3'd2;
			end
			OP_DUP: begin
				consume = 3'd1; cnt = 3'd2;
			end
			OP_DUP_X1: begin
				consume = 3'd2; cnt = 3'd3; sel[1] = SEL_V2;
			end
			OP_DUP_X2: begin
				need = 3'd2;
				if (v_w_q[1]) begin
					consume = 3'd2; cnt = 3'd3; sel[1] = SEL_V2;
				end else begin
					consume = 3'd3; cnt = 3'd4; sel[1] = SEL_V3; sel[2] = SEL_V2;
				end
			end
			OP_DUP2: begin
				need = 3'd1;
				if (v_w_q[0]) begin
					consume = 3'd1; cnt = 3'd2;
				end else begin
					consume = 3'd2; cnt = 3'd4; sel[0] = SEL_V2; sel[2] = SEL_V2;
				end
			end
			OP_DUP2_X1: begin
				need = 3'd1;
				if (v_w_q[0]) begin
					consume = 3'd2; cnt = 3'd3; sel[1] = SEL_V2;
				end else begin
					consume = 3'd3; cnt = 3'd5;
					sel[0] = SEL_V2; sel[2] = SEL_V3; sel[3] = SEL_V2;
				end
			end
			OP_DUP2_X2: begin
				need = 3'd2;
				if (count_q >= CNT_W'(2) && v_w_q[1] && !v_w_q[0]) begin
					inval = 1'b1;
				end else if (v_w_q[1]) begin
					consume = 3'd2; cnt = 3'd3; sel[1] = SEL_V2;
				end else if (v_w_q[0]) begin
					consume = 3'd3; cnt = 3'd4; sel[1] = SEL_V3; sel[2] = SEL_V2;
				end else begin
					need = 3'd3;
					sel[0] = SEL_V2;
					if (v_w_q[2]) begin
						consume = 3'd3; cnt = 3'd5; sel[2] = SEL_V3; sel[3] = SEL_V2;
					end else begin
						consume = 3'd4; cnt = 3'd6;
						sel[2] = SEL_V4; sel[3] = SEL_V3; sel[4] = SEL_V2;
					end
				end
			end
			OP_SWAP: begin
				consume = 3'd2; cnt = 3'd2; sel[1] = SEL_V2;
			end
			default: inval = 1'b1;
		endcase

		nx = (CNT_W+1)'(count_q);
		after = nx - (CNT_W+1)'(consume) + (CNT_W+1)'(cnt);
		if (inval)
			st = ST_INVALID;
		else if (nx < (CNT_W+1)'(need) || nx < (CNT_W+1)'(consume))
			st = ST_UNDER;
		else if (after > (CNT_W+1)'(STACK_DEPTH))
			st = ST_OVER;
		else
			st = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.dec && st == ST_OK) begin
			count_q <= CNT_W'(after);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q <= opcode;
			push_val_q <= push_value;
			push_w_q <= push_wide;
		end
		if (cmd.rd)
			rd_ok_q <= CNT_W'(cmd.idx) < count_q;
		if (cmd.cap_v) begin
			v_val_q[cmd.idx] <= rd_ok_q ? rdata_q[VALUE_WIDTH-1:0] : '0;
			v_w_q[cmd.idx] <= rd_ok_q & rdata_q[VALUE_WIDTH];
		end
		if (cmd.dec) begin
			stat_q <= st;
			base_q <= CNT_W'(nx - (CNT_W+1)'(consume));
			cnt_q <= (st == ST_OK) ? cnt : 3'd0;
			for (int i = 0; i < 6; i++)
				sel_q[i] <= sel[i];
		end
		if (cmd.top_cap)
			top_q <= rd_ok_q ? rdata_q : '0;
		if (cmd.load_out) begin
			status <= stat_q;
			stack_depth <= 7'(count_q);
			top_value <= top_q[VALUE_WIDTH-1:0];
			top_wide <= top_q[VALUE_WIDTH];
		end
	end

endmodule

// File: rtl/core/operand_stack_shuffle_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake          | beat fields
// in      | input     | in_valid/in_stall  | opcode, push_value, push_wide
// out     | output    | out_valid/out_stall| status, stack_depth, top_value, top_wide
//
// a beat goes from its acceptance to the result load in these steps: four reads
// of the top entries through the single read port, one decode step, one write
// per placed entry (none to six), a read of the new top, the load.
// the next beat is taken in the cycle after the load at the earliest.
// arst_n clears the controller and the depth count; the memory is not cleared.
// a result held under out_stall delays the next load, and input stays stalled until it.
module operand_stack_shuffle_unit
	import oss_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [63:0] push_value,
	input  logic        push_wide,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [6:0]  stack_depth,
	output logic [63:0] top_value,
	output logic        top_wide
);

	oss_cmd_t               cmd;
	oss_stat_t              stat;
	logic [VALUE_WIDTH-1:0] top_v;

	oss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	oss_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.opcode     (opcode),
		.push_value (push_value[VALUE_WIDTH-1:0]),
		.push_wide  (push_wide),
		.status     (status),
		.stack_depth(stack_depth),
		.top_value  (top_v),
		.top_wide   (top_wide)
	);

	assign top_value = 64'(top_v);

endmodule

// File: rtl/core/oss_checker.sv
`timescale 1ns / 1ps
module oss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [6:0]  stack_depth,
	input logic [63:0] top_value,
	input logic        top_wide
);

	// one item in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	a_empty_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_depth == 7'd0 |-> top_value == 64'd0 && !top_wide)
		else $error("empty stack reports a top entry");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(stack_depth) && $stable(top_value))
		else $error("stalled result changed");

endmodule

bind operand_stack_shuffle_unit oss_checker u_oss_checker (.*);

// File: tb/operand_stack_shuffle_checker.sv
`timescale 1ns / 1ps
module operand_stack_shuffle_checker
	import oss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [63:0] push_value,
	input  logic        push_wide,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [6:0]  stack_depth,
	input  logic [63:0] top_value,
	input  logic        top_wide,
	output int          fail_count,
	output int          pending_count
);

	localparam int DEPTH = STACK_DEPTH_DEF;

	typedef struct {
		logic [63:0] val;
		bit          wide;
	} slot_t;

	typedef struct {
		status_t     st;
		logic [6:0]  depth;
		logic [63:0] val;
		bit          wide;
	} stack_result_t;

	slot_t         shadow_stack[DEPTH];
	int            shadow_depth;
	stack_result_t expected_results[$];

	function automatic slot_t peek_slot(int i);
		slot_t e;
		e.val = '0;
		e.wide = 0;
		if (i < shadow_depth) e = shadow_stack[shadow_depth - 1 - i];
		return e;
	endfunction

	// applies one operation to the shadow stack and returns the status/top beat
	function automatic stack_result_t apply_stack_op(logic [3:0] op, logic [63:0] pv, bit pw);
		slot_t v1, v2, v3, v4, top;
		slot_t placed[6];
		int need, consume, cnt, base;
		status_t st;
		stack_result_t r;
		v1 = peek_slot(0);
		v2 = peek_slot(1);
		v3 = peek_slot(2);
		v4 = peek_slot(3);
		need = 0;
		consume = 0;
		cnt = 0;
		st = ST_OK;
		case (op)
			OP_PUSH: begin
				placed[0].val = pv;
				placed[0].wide = pw;
				cnt = 1;
			end
			OP_POP: consume = 1;
			OP_POP2: begin
				need = 1;
				consume = v1.wide ? 1 : 2;
			end
			OP_DUP: begin
				consume = 1;
				placed[0] = v1; placed[1] = v1; cnt = 2;
			end
			OP_DUP_X1: begin
				consume = 2;
				placed[0] = v1; placed[1] = v2; placed[2] = v1; cnt = 3;
			end
			OP_DUP_X2: begin
				need = 2;
				if (v2.wide) begin
					consume = 2;
					placed[0] = v1; placed[1] = v2; placed[2] = v1; cnt = 3;
				end else begin
					consume = 3;
					placed[0] = v1; placed[1] = v3; placed[2] = v2; placed[3] = v1; cnt = 4;
				end
			end
			OP_DUP2: begin
				need = 1;
				if (v1.wide) begin
					consume = 1;
					placed[0] = v1; placed[1] = v1; cnt = 2;
				end else begin
					consume = 2;
					placed[0] = v2; placed[1] = v1; placed[2] = v2; placed[3] = v1; cnt = 4;
				end
			end
			OP_DUP2_X1: begin
				need = 1;
				if (v1.wide) begin
					consume = 2;
					placed[0] = v1; placed[1] = v2; placed[2] = v1; cnt = 3;
				end else begin
					consume = 3;
					placed[0] = v2; placed[1] = v1; placed[2] = v3;
					placed[3] = v2; placed[4] = v1; cnt = 5;
				end
			end
			OP_DUP2_X2: begin
				need = 2;
				if (shadow_depth >= 2 && v2.wide && !v1.wide) begin
					st = ST_INVALID;
				end else if (v2.wide) begin
					consume = 2;
					placed[0] = v1; placed[1] = v2; placed[2] = v1; cnt = 3;
				end else if (v1.wide) begin
					consume = 3;
					placed[0] = v1; placed[1] = v3; placed[2] = v2; placed[3] = v1; cnt = 4;
				end else begin
					need = 3;
					if (v3.wide) begin
						consume = 3;
						placed[0] = v2; placed[1] = v1; placed[2] = v3;
						placed[3] = v2; placed[4] = v1; cnt = 5;
					end else begin
						consume = 4;
						placed[0] = v2; placed[1] = v1; placed[2] = v4;
						placed[3] = v3; placed[4] = v2; placed[5] = v1; cnt = 6;
					end
				end
			end
			OP_SWAP: begin
				consume = 2;
				placed[0] = v1; placed[1] = v2; cnt = 2;
			end
			default: st = ST_INVALID;
		endcase
		// a short stack under dup2_x2 is underflow even before the form is known
		if (st == ST_OK || (op == OP_DUP2_X2 && shadow_depth < need)) begin
			if (shadow_depth < need || shadow_depth < consume) begin
				st = ST_UNDER;
			end else if (shadow_depth - consume + cnt > DEPTH) begin
				st = ST_OVER;
			end else begin
				base = shadow_depth - consume;
				for (int i = 0; i < cnt; i++) shadow_stack[base + i] = placed[i];
				shadow_depth = base + cnt;
			end
		end
		top = peek_slot(0);
		r.st = st;
		r.depth = 7'(shadow_depth);
		r.val = top.val;
		r.wide = top.wide;
		return r;
	endfunction

	assign pending_count = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_depth = 0;
			expected_results.delete();
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_stack_op(opcode, push_value, push_wide));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					stack_result_t e;
					e = expected_results.pop_front();
					if (status !== e.st || stack_depth !== e.depth || top_value !== e.val
							|| top_wide !== e.wide)
						fail_count <= fail_count + 1;
					if (status !== e.st)
						$error("status: expected %0d, got %0d", e.st, status);
					if (stack_depth !== e.depth)
						$error("stack_depth: expected %0d, got %0d", e.depth, stack_depth);
					if (top_value !== e.val)
						$error("top_value: expected %h, got %h", e.val, top_value);
					if (top_wide !== e.wide)
						$error("top_wide: expected %0d, got %0d", e.wide, top_wide);
				end
			end
		end
	end

endmodule

// File: tb/tb_operand_stack_shuffle_unit.sv
`timescale 1ns / 1ps
module tb_operand_stack_shuffle_unit
	import oss_pkg::*;
();

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  opcode;
	logic [63:0] push_value;
	logic        push_wide;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [6:0]  stack_depth;
	logic [63:0] top_value;
	logic        top_wide;
	int          fail_count;
	int          pending_count;
	int          burst_left;

	operand_stack_shuffle_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .push_value(push_value), .push_wide(push_wide),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .stack_depth(stack_depth), .top_value(top_value),
		.top_wide(top_wide)
	);

	operand_stack_shuffle_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .push_value(push_value), .push_wide(push_wide),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .stack_depth(stack_depth), .top_value(top_value),
		.top_wide(top_wide),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// offers one beat and holds it until taken; bursts end with a random gap in two cases of three
	task automatic send_beat(logic [3:0] op, logic [63:0] val, logic wide);
		in_valid <= 1;
		opcode <= op;
		push_value <= val;
		push_wide <= wide;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// receiver: stall density changes now and then, with one long hold-off
	initial begin
		int cyc;
		int pct;
		int hold_left;
		out_stall <= 0;
		cyc = 0;
		pct = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 300 == 0) pct = $urandom_range(0, 3) * 25;
			if (cyc == 3000) hold_left = 600;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	initial begin
		bit filling;
		int wait_cycles;
		logic [3:0] op;
		arst_n <= 0;
		in_valid <= 0;
		opcode <= OP_PUSH;
		push_value <= '0;
		push_wide <= 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// write the bottom slots first so later short-stack reads see written memory
		for (int i = 0; i < 8; i++) send_beat(OP_PUSH, rand_value(), i[0]);
		for (int i = 0; i < 8; i++) send_beat(OP_POP, '0, 0);
		send_beat(OP_POP, '0, 0);
		send_beat(OP_POP2, '0, 0);
		send_beat(OP_PUSH, '0, 1);
		send_beat(OP_PUSH, '1, 0);
		send_beat(OP_DUP2_X2, '0, 0);	// wide under narrow: invalid form
		send_beat(OP_PUSH, 64'h8000_0000_0000_0001, 0);
		send_beat(OP_DUP2_X2, '0, 0);	// narrow, narrow over wide
		send_beat(OP_PUSH, 64'h7fff_ffff_ffff_fffe, 1);
		send_beat(OP_DUP2_X2, '0, 0);	// wide over narrow
		send_beat(4'(OP_SWAP + 1), '0, 0);
		send_beat(4'hf, '0, 0);
		send_beat(OP_SWAP, '0, 0);
		send_beat(OP_DUP_X1, '0, 0);
		send_beat(OP_DUP_X2, '0, 0);
		send_beat(OP_DUP2_X1, '0, 0);
		send_beat(OP_DUP, '0, 0);
		send_beat(OP_DUP2, '0, 0);
		send_beat(OP_POP2, '0, 0);

		// alternate between growing and draining phases to hit full and empty
		filling = 1;
		for (int n = 0; n < 1500; n++) begin
			if (n % 90 == 0) filling = !filling;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: op = filling ? OP_PUSH : OP_POP;
				5, 6: op = filling ? OP_PUSH : OP_POP2;
				7: op = OP_PUSH;
				8: op = OP_DUP;
				9: op = OP_DUP_X1;
				10: op = OP_DUP_X2;
				11: op = OP_DUP2;
				12: op = OP_DUP2_X1;
				13, 14: op = OP_DUP2_X2;
				15: op = OP_SWAP;
				16: op = OP_POP;
				17: op = OP_POP2;
				18: op = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(OP_SWAP + 1, 15))
					: OP_PUSH;
				default: op = filling ? OP_DUP2 : OP_POP;
			endcase
			send_beat(op, rand_value(), $urandom_range(0, 1));
		end
		in_valid <= 0;

		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
